// ----- hw/rtl/rgst_pkg.sv -----
// Package: shared opcodes, status codes and payload types for the slot table
`default_nettype none
package rgst_pkg;
    localparam logic [2:0] OP_ADDREF  = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_FIND    = 3'd2;
    localparam logic [2:0] OP_CHECK   = 3'd3;
    localparam logic [2:0] OP_LIB_ADD = 3'd4;
    localparam logic [2:0] OP_LIB_DROP = 3'd5;
    localparam logic [2:0] OP_CLR_DIRTY = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL_KEY = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] key;
        logic [5:0]  slot_index;
        logic [15:0] handle_generation;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_index;
        logic [15:0] result_generation;
        logic        handle_valid;
        logic [31:0] key_out;
        logic [6:0]  span_count;
        logic [6:0]  live_count;
        logic        dirty_flag;
    } t_rsp;
endpackage
`default_nettype wire

// ----- hw/rtl/rgst_if.sv -----
// Interfaces: valid/ready channels for request and response words
`default_nettype none
interface rgst_req_if;
    logic             valid;
    logic             ready;
    rgst_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rgst_rsp_if;
    logic             valid;
    logic             ready;
    rgst_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rgst_cell.sv -----
// Slot cell: one slot's state plus the scan token passed along the chain
`default_nettype none
module rgst_cell #(
    parameter int GEN_BITS = 16,
    parameter bit RESERVED = 1'b0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // scan input from left neighbor: token marks which cell is sampled
    input  wire logic                i_tok,
    output logic                     o_tok,
    // write command from the controller
    input  wire logic                i_wr,
    input  wire logic [31:0]         i_wr_key,
    input  wire logic                i_wr_alive,
    input  wire logic                i_wr_lib,
    input  wire logic [15:0]         i_wr_refs,
    input  wire logic                i_wr_bump,
    // cell contents
    output logic [31:0]              o_key,
    output logic                     o_alive,
    output logic                     o_lib,
    output logic [15:0]              o_refs,
    output logic [GEN_BITS-1:0]      o_gen
);
    logic [31:0]         r_key;
    logic                r_alive;
    logic                r_lib;
    logic [15:0]         r_refs;
    logic [GEN_BITS-1:0] r_gen;
    logic                r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_alive <= RESERVED;
            r_lib   <= 1'b0;
            r_refs  <= '0;
            r_gen   <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_wr && !RESERVED) begin
                r_key   <= i_wr_key;
                r_alive <= i_wr_alive;
                r_lib   <= i_wr_lib;
                r_refs  <= i_wr_refs;
                if (i_wr_bump) begin
                    r_gen <= r_gen + 1'b1;
                end
            end
        end
    end

    assign o_tok   = r_tok;
    assign o_key   = r_key;
    assign o_alive = r_alive;
    assign o_lib   = r_lib;
    assign o_refs  = r_refs;
    assign o_gen   = r_gen;
endmodule
`default_nettype wire

// ----- hw/rtl/refcounted_generational_slot_table.sv -----
// Flow: an accepted request runs a key search as a token walks the cell chain (S_SCAN),
// then an update step (S_EXEC), then a pass over the cells tallying live slots (S_CNT).
// A new request is taken only in S_IDLE, once both passes over the chain are done.
// The response waits in an output register; the next item is taken meanwhile and its
// last tally step holds while that register is still full.
// Reset: synchronous active low; reserved slots alive, other cell state cleared; free stack unset.
`default_nettype none
module refcounted_generational_slot_table #(
    parameter int SLOTS = 64,
    parameter int RESERVED_SLOTS = 2,
    parameter int GEN_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rgst_req_if.sink   i_req,
    rgst_rsp_if.source o_rsp
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_CNT  = 2'd3;

    logic [1:0] r_state;
    rgst_pkg::t_req r_req;
    logic [CW-1:0] r_pos;
    logic r_found;
    logic [IW-1:0] r_fidx;
    logic [CW-1:0] r_hw;
    logic [CW-1:0] r_fdepth;
    logic r_dirty;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_live;
    rgst_pkg::t_rsp r_rsp;
    rgst_pkg::t_rsp r_pend;
    logic r_rsp_valid;
    logic [IW-1:0] r_stack [SLOTS];
    logic [IW-1:0] r_stack_rd;

    logic [SLOTS-1:0] w_tok;
    logic [31:0] c_key [SLOTS];
    logic [SLOTS-1:0] c_alive, c_lib;
    logic [15:0] c_refs [SLOTS];
    logic [GEN_BITS-1:0] c_gen [SLOTS];

    logic [SLOTS-1:0] w_wr;
    logic [31:0] w_wr_key;
    logic w_wr_alive, w_wr_lib, w_wr_bump;
    logic [15:0] w_wr_refs;
    logic [IW-1:0] w_widx;
    logic w_do_wr;

    // token entering cell 0 starts the scan
    logic w_start;
    assign w_start = (r_state == S_IDLE) && i_req.valid && i_req.ready;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            rgst_cell #(
                .GEN_BITS(GEN_BITS),
                .RESERVED(g < RESERVED_SLOTS)
            ) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n),
                .i_tok((g == 0) ? w_start : w_tok[(g == 0) ? 0 : g-1]),
                .o_tok(w_tok[g]),
                .i_wr(w_wr[g]), .i_wr_key(w_wr_key), .i_wr_alive(w_wr_alive),
                .i_wr_lib(w_wr_lib), .i_wr_refs(w_wr_refs), .i_wr_bump(w_wr_bump),
                .o_key(c_key[g]), .o_alive(c_alive[g]), .o_lib(c_lib[g]),
                .o_refs(c_refs[g]), .o_gen(c_gen[g])
            );
        end
    endgenerate

    // tapped cell: one-hot token selects the cell under scan
    logic [31:0] w_tkey;
    logic w_talive;
    always_comb begin
        w_tkey = '0;
        w_talive = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_tok[i]) begin
                w_tkey = c_key[i];
                w_talive = c_alive[i];
            end
        end
    end

    logic [IW-1:0] w_pidx;
    assign w_pidx = r_pos[IW-1:0];
    logic w_in_hw;
    assign w_in_hw = (r_pos < r_hw);

    // execute stage decode
    logic [IW-1:0] w_idx;
    logic [31:0] e_key;
    logic e_alive, e_lib;
    logic [15:0] e_refs;
    logic [GEN_BITS-1:0] e_gen;
    logic w_nullkey, w_claim, w_full, w_use_stack;
    always_comb begin
        w_nullkey = (r_req.opcode <= rgst_pkg::OP_LIB_DROP) &&
                    (r_req.opcode != rgst_pkg::OP_CHECK) && (r_req.key == '0);
        w_use_stack = (r_fdepth != '0);
        w_full = !w_use_stack && (r_hw >= CW'(SLOTS));
        w_claim = !r_found;
        if (r_found) w_idx = r_fidx;
        else if (w_use_stack) w_idx = r_stack_rd;
        else w_idx = r_hw[IW-1:0];
        if (r_req.opcode == rgst_pkg::OP_CHECK) w_idx = r_req.slot_index[IW-1:0];
        e_key = c_key[w_idx];
        e_alive = c_alive[w_idx];
        e_lib = c_lib[w_idx];
        e_refs = c_refs[w_idx];
        e_gen = c_gen[w_idx];
    end

    rgst_pkg::t_rsp w_rsp;
    logic w_push;
    logic w_pop, w_grow, w_setdirty;
    always_comb begin
        w_rsp = '0;
        w_do_wr = 1'b0;
        w_widx = w_idx;
        w_wr_key = e_key;
        w_wr_alive = e_alive;
        w_wr_lib = e_lib;
        w_wr_refs = e_refs;
        w_wr_bump = 1'b0;
        w_push = 1'b0;
        w_pop = 1'b0;
        w_grow = 1'b0;
        w_setdirty = 1'b0;
        if (w_nullkey) begin
            w_rsp.status = rgst_pkg::ST_NULL_KEY;
        end else begin
            unique case (r_req.opcode) inside
                rgst_pkg::OP_ADDREF, rgst_pkg::OP_LIB_ADD: begin
                    if (w_claim && w_full) begin
                        w_rsp.status = rgst_pkg::ST_FULL;
                    end else begin
                        w_do_wr = 1'b1;
                        if (w_claim) begin
                            w_wr_key = r_req.key;
                            w_wr_alive = 1'b1;
                            w_wr_lib = 1'b0;
                            w_wr_refs = '0;
                            w_setdirty = 1'b1;
                            w_pop = w_use_stack;
                            w_grow = !w_use_stack;
                        end
                        if (r_req.opcode == rgst_pkg::OP_ADDREF) begin
                            if (w_wr_refs != 16'hFFFF) w_wr_refs = w_wr_refs + 16'd1;
                        end else begin
                            w_wr_lib = 1'b1;
                        end
                        w_rsp.result_index = 6'(w_idx);
                        w_rsp.result_generation = 16'(e_gen);
                        w_rsp.handle_valid = 1'b1;
                    end
                end
                rgst_pkg::OP_RELEASE, rgst_pkg::OP_FIND, rgst_pkg::OP_LIB_DROP: begin
                    if (!r_found) begin
                        w_rsp.status = rgst_pkg::ST_NOT_FOUND;
                    end else begin
                        w_rsp.handle_valid = 1'b1;
                        w_rsp.result_index = 6'(w_idx);
                        w_rsp.result_generation = 16'(e_gen);
                        if (r_req.opcode == rgst_pkg::OP_RELEASE) begin
                            if (e_refs == '0) begin
                                w_rsp.status = rgst_pkg::ST_UNDERFLOW;
                            end else begin
                                w_do_wr = 1'b1;
                                w_wr_refs = e_refs - 16'd1;
                            end
                        end else if (r_req.opcode == rgst_pkg::OP_LIB_DROP && e_lib) begin
                            w_do_wr = 1'b1;
                            w_wr_lib = 1'b0;
                        end
                        // free once unreferenced and out of the library
                        if (w_do_wr && !w_wr_lib && w_wr_refs == '0) begin
                            w_wr_key = '0;
                            w_wr_alive = 1'b0;
                            w_wr_bump = 1'b1;
                            w_push = 1'b1;
                            w_setdirty = 1'b1;
                            w_rsp.result_generation = 16'(e_gen + 1'b1);
                        end
                    end
                end
                rgst_pkg::OP_CHECK: begin
                    w_rsp.result_index = r_req.slot_index;
                    if (32'(r_req.slot_index) < 32'(SLOTS)) begin
                        w_rsp.result_generation = 16'(e_gen);
                        if (CW'(r_req.slot_index) < r_hw && e_alive &&
                            32'(e_gen) == 32'(r_req.handle_generation)) begin
                            w_rsp.handle_valid = 1'b1;
                            w_rsp.key_out = e_key;
                        end
                    end
                    if (!w_rsp.handle_valid) w_rsp.status = rgst_pkg::ST_NOT_FOUND;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_wr = '0;
        if (r_state == S_EXEC && w_do_wr) w_wr[w_widx] = 1'b1;
    end

    // final tally step and response load
    logic w_out_free, w_last_cnt, w_load;
    assign w_out_free = !r_rsp_valid || o_rsp.ready;
    assign w_last_cnt = (r_state == S_CNT) && (r_pos == CW'(SLOTS - 1));
    assign w_load = w_last_cnt && w_out_free;

    rgst_pkg::t_rsp w_final;
    always_comb begin
        w_final = r_pend;
        w_final.span_count = 7'((c_alive[w_pidx] && w_in_hw) ? r_pos + 1'b1 : r_cnt);
        w_final.live_count = 7'((c_alive[w_pidx] && w_in_hw &&
            w_pidx >= IW'(RESERVED_SLOTS)) ? r_live + 1'b1 : r_live);
        w_final.dirty_flag = r_dirty;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && w_push && r_fdepth < CW'(SLOTS)) begin
            r_stack[r_fdepth[IW-1:0]] <= w_idx;
        end
        r_stack_rd <= r_stack[r_fdepth[IW-1:0] - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw <= CW'(RESERVED_SLOTS);
            r_fdepth <= '0;
            r_dirty <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_pos <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_req <= i_req.data;
                        r_pos <= '0;
                        r_found <= 1'b0;
                        r_fidx <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // search for the key, one cell per cycle
                    if (w_pidx >= IW'(RESERVED_SLOTS) && w_in_hw && w_talive &&
                        w_tkey == r_req.key && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx <= w_pidx;
                    end
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == CW'(SLOTS - 1)) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pend <= w_rsp;
                    if (w_pop) r_fdepth <= r_fdepth - 1'b1;
                    if (w_push && r_fdepth < CW'(SLOTS)) r_fdepth <= r_fdepth + 1'b1;
                    if (w_grow) r_hw <= r_hw + 1'b1;
                    if (w_setdirty) r_dirty <= 1'b1;
                    if (!w_nullkey && r_req.opcode == rgst_pkg::OP_CLR_DIRTY) r_dirty <= 1'b0;
                    r_cnt <= '0;
                    r_live <= '0;
                    r_pos <= '0;
                    r_state <= S_CNT;
                end
                default: begin
                    // tally live slots, one per cycle, direct read; last step stalls on output
                    if (!w_last_cnt) begin
                        if (c_alive[w_pidx] && w_in_hw) begin
                            r_cnt <= r_pos + 1'b1;
                            if (w_pidx >= IW'(RESERVED_SLOTS)) r_live <= r_live + 1'b1;
                        end
                        r_pos <= r_pos + 1'b1;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (w_load) begin
                r_rsp_valid <= 1'b1;
                r_rsp <= w_final;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
